FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SPS_ASSERT_SAME(lbl, ante, cons)
`define SPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/sps_pkg.sv
package sps_pkg;

	localparam int MAX_LEADING_ZEROS = 16;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_unit;
		logic       last_of_unit;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [20:0] pic_width;
		logic [21:0] pic_height;
		logic        interlaced;
		logic        cropping_on;
		logic [17:0] crop_right_px;
		logic [18:0] crop_bottom_px;
		logic [16:0] ref_frame_count;
		logic        timing_present;
		logic [31:0] units_in_tick;
		logic [31:0] tick_time_scale;
	} out_item_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_PROFILE   = 3'd1;
	localparam logic [2:0] ST_FIXED     = 3'd2;
	localparam logic [2:0] ST_POC_TYPE  = 3'd3;
	localparam logic [2:0] ST_POC_CYCLE = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;

	localparam logic CFG_SKIP = 1'b0;
	localparam logic CFG_POC  = 1'b1;

	localparam logic [5:0] S_IDLE = 6'd0, S_PROFILE = 6'd1, S_CONSTR = 6'd2,
		S_RESERVED = 6'd3, S_LEVEL = 6'd4, S_SPS_ID = 6'd5, S_CHROMA = 6'd6,
		S_DEPTH_L = 6'd7, S_DEPTH_C = 6'd8, S_LOSSLESS = 6'd9, S_MTX_FLAG = 6'd10,
		S_LIST_FLAG = 6'd11, S_LIST_DELTA = 6'd12, S_LOG2_FN = 6'd13,
		S_POC_TYPE = 6'd14, S_POC_LSB = 6'd15, S_DELTA_ZERO = 6'd16,
		S_OFF_NONREF = 6'd17, S_OFF_TB = 6'd18, S_CYCLE_LEN = 6'd19,
		S_CYCLE_ITEM = 6'd20, S_NUM_REF = 6'd21, S_GAPS = 6'd22, S_WIDTH = 6'd23,
		S_HEIGHT = 6'd24, S_FRAME_ONLY = 6'd25, S_MBAFF = 6'd26, S_DIRECT8 = 6'd27,
		S_CROP_FLAG = 6'd28, S_CROP_L = 6'd29, S_CROP_R = 6'd30, S_CROP_T = 6'd31,
		S_CROP_B = 6'd32, S_VUI_FLAG = 6'd33, S_AR_FLAG = 6'd34, S_AR_IDC = 6'd35,
		S_SAR = 6'd36, S_OVS_FLAG = 6'd37, S_OVS_APPR = 6'd38, S_VST_FLAG = 6'd39,
		S_VST_BITS = 6'd40, S_COLOUR_FLAG = 6'd41, S_COLOUR = 6'd42,
		S_LOC_FLAG = 6'd43, S_LOC_TOP = 6'd44, S_LOC_BOT = 6'd45,
		S_TIMING_FLAG = 6'd46, S_UNITS = 6'd47, S_SCALE = 6'd48, S_FIXED = 6'd49;

	// Bit count of a fixed-width field; zero marks an Exp-Golomb field.
	function automatic logic [5:0] step_width(input logic [5:0] s);
		case (s)
			S_PROFILE, S_LEVEL, S_AR_IDC: step_width = 6'd8;
			S_CONSTR, S_RESERVED, S_VST_BITS: step_width = 6'd4;
			S_SAR, S_UNITS, S_SCALE: step_width = 6'd32;
			S_COLOUR: step_width = 6'd24;
			S_LOSSLESS, S_MTX_FLAG, S_LIST_FLAG, S_DELTA_ZERO, S_GAPS, S_FRAME_ONLY,
			S_MBAFF, S_DIRECT8, S_CROP_FLAG, S_VUI_FLAG, S_AR_FLAG, S_OVS_FLAG,
			S_OVS_APPR, S_VST_FLAG, S_COLOUR_FLAG, S_LOC_FLAG, S_TIMING_FLAG,
			S_FIXED: step_width = 6'd1;
			default: step_width = 6'd0;
		endcase
	endfunction

	function automatic logic is_high(input logic [7:0] p);
		is_high = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) ||
			(p == 8'd244) || (p == 8'd44);
	endfunction

endpackage

FILE: rtl/sps_front.sv
module sps_front
	import sps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_stall,
	input  in_item_t byte_item,
	output logic     q_valid,
	output in_item_t q_head,
	input  logic     q_pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	in_item_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [PW:0]    count_q;
	logic           push;

	assign byte_stall = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign push       = byte_valid && !byte_stall;
	assign q_valid    = (count_q != '0);
	assign q_head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/sps_exec.sv
module sps_exec
	import sps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [7:0] cfg_data,
	input  logic      q_valid,
	input  in_item_t  q_head,
	output logic      q_pop,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res_item
);

	logic [2:0]  cfg_skip_q;
	logic [7:0]  cfg_poc_q;

	logic        busy_q, busy_d;
	logic [2:0]  bit_q, bit_d;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [5:0]  step_q, step_d;
	logic [2:0]  skip_q, skip_d;
	logic [31:0] shift_q, shift_d;
	logic [5:0]  left_q, left_d;
	logic [4:0]  zc_q, zc_d;
	logic [7:0]  profile_q, profile_d;
	logic        frame_only_q, frame_only_d;
	logic [7:0]  loop_q, loop_d;
	logic [3:0]  list_num_q, list_num_d;
	logic [6:0]  list_idx_q, list_idx_d;
	logic [7:0]  list_last_q, list_last_d;
	logic [20:0] width_q, width_d;
	logic [21:0] height_q, height_d;
	logic [17:0] crop_r_q, crop_r_d;
	logic [18:0] crop_b_q, crop_b_d;
	logic        crop_flag_q, crop_flag_d;
	logic [16:0] ref_q, ref_d;
	logic [31:0] units_q, units_d;
	logic [31:0] scale_q, scale_d;
	logic        timing_q, timing_d;
	logic        fin;
	logic [2:0]  fin_st;
	out_item_t   res_d;
	out_item_t   res_q;
	logic        res_valid_q;

	assign q_pop     = !busy_q && q_valid && !res_valid_q;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	always_comb begin
		logic        bit_v;
		logic        cmp;
		logic [31:0] val;
		logic [31:0] sh;
		logic        do_go;
		logic [5:0]  go_s;
		logic [7:0]  nx;
		logic [6:0]  idx;
		logic [18:0] cb;
		logic [16:0] v1;
		logic [5:0]  nl_s;

		busy_d = busy_q; bit_d = bit_q; step_d = step_q; skip_d = skip_q;
		shift_d = shift_q; left_d = left_q; zc_d = zc_q; profile_d = profile_q;
		frame_only_d = frame_only_q; loop_d = loop_q; list_num_d = list_num_q;
		list_idx_d = list_idx_q; list_last_d = list_last_q; width_d = width_q;
		height_d = height_q; crop_r_d = crop_r_q; crop_b_d = crop_b_q;
		crop_flag_d = crop_flag_q; ref_d = ref_q; units_d = units_q;
		scale_d = scale_q; timing_d = timing_q;
		fin = 1'b0; fin_st = ST_OK; do_go = 1'b0; go_s = S_IDLE;
		cmp = 1'b0; val = '0;
		bit_v = byte_q[bit_q];
		sh = {shift_q[30:0], bit_v};
		nx = '0; idx = '0; cb = '0;
		v1 = val[16:0] + 17'd1;
		nl_s = (list_num_q >= 4'd7) ? S_LOG2_FN : S_LIST_FLAG;

		if (q_pop) begin
			busy_d = 1'b1;
			bit_d  = 3'd7;
			if (q_head.first_of_unit) begin
				skip_d = cfg_skip_q; profile_d = '0; frame_only_d = 1'b1; loop_d = '0;
				list_num_d = '0; list_idx_d = '0; list_last_d = 8'd8;
				width_d = '0; height_d = '0; crop_r_d = '0; crop_b_d = '0;
				crop_flag_d = 1'b0; ref_d = '0; units_d = '0; scale_d = '0;
				timing_d = 1'b0;
				do_go = 1'b1; go_s = S_PROFILE;
			end
		end else if (busy_q) begin
			if (step_q == S_IDLE) begin
				busy_d = 1'b0;
			end else if (skip_q != '0) begin
				skip_d = skip_q - 1'b1;
				busy_d = 1'b0;
				if (last_q) begin
					fin = 1'b1; fin_st = ST_TRUNC;
				end
			end else begin
				// One bit of the current field per cycle.
				if (step_width(step_q) != '0) begin
					shift_d = sh;
					left_d  = left_q - 1'b1;
					if (left_q == 6'd1) begin
						cmp = 1'b1; val = sh;
					end
				end else if (left_q == '0) begin
					if (!bit_v && zc_q < 5'(MAX_LEADING_ZEROS)) begin
						zc_d = zc_q + 1'b1;
					end else if (zc_q == '0) begin
						cmp = 1'b1; val = '0;
					end else begin
						left_d = {1'b0, zc_q};
					end
				end else begin
					shift_d = sh;
					left_d  = left_q - 1'b1;
					if (left_q == 6'd1) begin
						cmp = 1'b1; val = ((32'd1 << zc_q) - 32'd1) + sh;
					end
				end
				v1 = val[16:0] + 17'd1;

				if (cmp) begin
					case (step_q)
						S_PROFILE: begin
							if (!(val == 32'd66 || val == 32'd77 || val == 32'd88 ||
								(val[31:8] == '0 && is_high(val[7:0])))) begin
								fin = 1'b1; fin_st = ST_PROFILE;
							end else begin
								profile_d = val[7:0]; do_go = 1'b1; go_s = S_CONSTR;
							end
						end
						S_CONSTR: begin do_go = 1'b1; go_s = S_RESERVED; end
						S_RESERVED, S_CHROMA, S_DEPTH_L, S_DEPTH_C, S_LOSSLESS: begin
							if ((step_q == S_CHROMA) ? (val != 32'd1) : (val != '0)) begin
								fin = 1'b1; fin_st = ST_FIXED;
							end else begin
								do_go = 1'b1;
								go_s = (step_q == S_RESERVED) ? S_LEVEL : step_q + 6'd1;
							end
						end
						S_LEVEL: begin do_go = 1'b1; go_s = S_SPS_ID; end
						S_SPS_ID: begin
							do_go = 1'b1; go_s = is_high(profile_q) ? S_CHROMA : S_LOG2_FN;
						end
						S_MTX_FLAG: begin
							do_go = 1'b1;
							if (val[0]) begin
								list_num_d = '0; go_s = S_LIST_FLAG;
							end else begin
								go_s = S_LOG2_FN;
							end
						end
						S_LIST_FLAG: begin
							do_go = 1'b1;
							if (val[0]) begin
								list_last_d = 8'd8; list_idx_d = '0; go_s = S_LIST_DELTA;
							end else begin
								list_num_d = list_num_q + 1'b1; go_s = nl_s;
							end
						end
						S_LIST_DELTA: begin
							do_go = 1'b1;
							nx = val[0] ? (list_last_q + val[8:1] + 8'd1)
								: (list_last_q - val[8:1]);
							idx = list_idx_q + 1'b1;
							if (nx == '0) begin
								list_num_d = list_num_q + 1'b1; go_s = nl_s;
							end else begin
								list_last_d = nx;
								list_idx_d  = idx;
								if (idx >= ((list_num_q < 4'd6) ? 7'd16 : 7'd64)) begin
									list_num_d = list_num_q + 1'b1; go_s = nl_s;
								end else begin
									go_s = S_LIST_DELTA;
								end
							end
						end
						S_LOG2_FN: begin do_go = 1'b1; go_s = S_POC_TYPE; end
						S_POC_TYPE: begin
							do_go = 1'b1;
							if (val == '0) go_s = S_POC_LSB;
							else if (val == 32'd1) go_s = S_DELTA_ZERO;
							else if (val == 32'd2) go_s = S_NUM_REF;
							else begin
								do_go = 1'b0; fin = 1'b1; fin_st = ST_POC_TYPE;
							end
						end
						S_POC_LSB: begin do_go = 1'b1; go_s = S_NUM_REF; end
						S_DELTA_ZERO: begin do_go = 1'b1; go_s = S_OFF_NONREF; end
						S_OFF_NONREF: begin do_go = 1'b1; go_s = S_OFF_TB; end
						S_OFF_TB: begin do_go = 1'b1; go_s = S_CYCLE_LEN; end
						S_CYCLE_LEN: begin
							if (val > {24'd0, cfg_poc_q}) begin
								fin = 1'b1; fin_st = ST_POC_CYCLE;
							end else begin
								loop_d = val[7:0]; do_go = 1'b1;
								go_s = (val[7:0] != '0) ? S_CYCLE_ITEM : S_NUM_REF;
							end
						end
						S_CYCLE_ITEM: begin
							loop_d = loop_q - 1'b1; do_go = 1'b1;
							go_s = (loop_q != 8'd1) ? S_CYCLE_ITEM : S_NUM_REF;
						end
						S_NUM_REF: begin ref_d = val[16:0]; do_go = 1'b1; go_s = S_GAPS; end
						S_GAPS: begin do_go = 1'b1; go_s = S_WIDTH; end
						S_WIDTH: begin width_d = {v1, 4'd0}; do_go = 1'b1; go_s = S_HEIGHT; end
						S_HEIGHT: begin
							height_d = {1'b0, v1, 4'd0}; do_go = 1'b1; go_s = S_FRAME_ONLY;
						end
						S_FRAME_ONLY: begin
							frame_only_d = val[0]; do_go = 1'b1;
							if (!val[0]) begin
								height_d = {height_q[20:0], 1'b0}; go_s = S_MBAFF;
							end else begin
								go_s = S_DIRECT8;
							end
						end
						S_MBAFF: begin do_go = 1'b1; go_s = S_DIRECT8; end
						S_DIRECT8: begin do_go = 1'b1; go_s = S_CROP_FLAG; end
						S_CROP_FLAG: begin
							crop_flag_d = val[0]; do_go = 1'b1;
							go_s = val[0] ? S_CROP_L : S_VUI_FLAG;
						end
						S_CROP_L: begin do_go = 1'b1; go_s = S_CROP_R; end
						S_CROP_R: begin
							crop_r_d = {val[16:0], 1'b0}; do_go = 1'b1; go_s = S_CROP_T;
						end
						S_CROP_T: begin do_go = 1'b1; go_s = S_CROP_B; end
						S_CROP_B: begin
							cb = frame_only_q ? {1'b0, val[16:0], 1'b0} : {val[16:0], 2'b00};
							crop_b_d = cb;
							height_d = (height_q >= {3'd0, cb}) ? height_q - {3'd0, cb} : '0;
							do_go = 1'b1; go_s = S_VUI_FLAG;
						end
						S_VUI_FLAG: begin
							if (val[0]) begin
								do_go = 1'b1; go_s = S_AR_FLAG;
							end else begin
								fin = 1'b1; fin_st = ST_OK;
							end
						end
						S_AR_FLAG: begin do_go = 1'b1; go_s = val[0] ? S_AR_IDC : S_OVS_FLAG; end
						S_AR_IDC: begin
							do_go = 1'b1; go_s = (val == 32'd255) ? S_SAR : S_OVS_FLAG;
						end
						S_SAR: begin do_go = 1'b1; go_s = S_OVS_FLAG; end
						S_OVS_FLAG: begin
							do_go = 1'b1; go_s = val[0] ? S_OVS_APPR : S_VST_FLAG;
						end
						S_OVS_APPR: begin do_go = 1'b1; go_s = S_VST_FLAG; end
						S_VST_FLAG: begin
							do_go = 1'b1; go_s = val[0] ? S_VST_BITS : S_LOC_FLAG;
						end
						S_VST_BITS: begin do_go = 1'b1; go_s = S_COLOUR_FLAG; end
						S_COLOUR_FLAG: begin
							do_go = 1'b1; go_s = val[0] ? S_COLOUR : S_LOC_FLAG;
						end
						S_COLOUR: begin do_go = 1'b1; go_s = S_LOC_FLAG; end
						S_LOC_FLAG: begin
							do_go = 1'b1; go_s = val[0] ? S_LOC_TOP : S_TIMING_FLAG;
						end
						S_LOC_TOP: begin do_go = 1'b1; go_s = S_LOC_BOT; end
						S_LOC_BOT: begin do_go = 1'b1; go_s = S_TIMING_FLAG; end
						S_TIMING_FLAG: begin
							if (val[0]) begin
								timing_d = 1'b1; do_go = 1'b1; go_s = S_UNITS;
							end else begin
								fin = 1'b1; fin_st = ST_OK;
							end
						end
						S_UNITS: begin units_d = val; do_go = 1'b1; go_s = S_SCALE; end
						S_SCALE: begin scale_d = val; do_go = 1'b1; go_s = S_FIXED; end
						S_FIXED: begin fin = 1'b1; fin_st = ST_OK; end
						default: begin do_go = 1'b1; go_s = S_IDLE; end
					endcase
				end

				if (fin) begin
					busy_d = 1'b0;
				end else if (bit_q == '0) begin
					busy_d = 1'b0;
					// A unit that ends before the parse does reports truncation.
					if (last_q && !(do_go && go_s == S_IDLE)) begin
						fin = 1'b1; fin_st = ST_TRUNC;
					end
				end else begin
					bit_d = bit_q - 1'b1;
				end
			end
		end

		if (do_go) begin
			step_d  = go_s;
			shift_d = '0;
			zc_d    = '0;
			left_d  = step_width(go_s);
		end
		if (fin) begin
			step_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_skip_q <= 3'd5;
			cfg_poc_q  <= 8'd128;
			busy_q <= 1'b0; bit_q <= '0; byte_q <= '0; last_q <= 1'b0;
			step_q <= S_IDLE; skip_q <= '0; shift_q <= '0; left_q <= '0; zc_q <= '0;
			profile_q <= '0; frame_only_q <= 1'b1; loop_q <= '0; list_num_q <= '0;
			list_idx_q <= '0; list_last_q <= 8'd8; width_q <= '0; height_q <= '0;
			crop_r_q <= '0; crop_b_q <= '0; crop_flag_q <= 1'b0; ref_q <= '0;
			units_q <= '0; scale_q <= '0; timing_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SKIP: cfg_skip_q <= cfg_data[2:0];
					CFG_POC:  cfg_poc_q  <= cfg_data;
					default:  cfg_poc_q  <= cfg_poc_q;
				endcase
			end
			if (q_pop) begin
				byte_q <= q_head.data_byte;
				last_q <= q_head.last_of_unit;
			end
			busy_q <= busy_d; bit_q <= bit_d; step_q <= step_d; skip_q <= skip_d;
			shift_q <= shift_d; left_q <= left_d; zc_q <= zc_d; profile_q <= profile_d;
			frame_only_q <= frame_only_d; loop_q <= loop_d; list_num_q <= list_num_d;
			list_idx_q <= list_idx_d; list_last_q <= list_last_d; width_q <= width_d;
			height_q <= height_d; crop_r_q <= crop_r_d; crop_b_q <= crop_b_d;
			crop_flag_q <= crop_flag_d; ref_q <= ref_d; units_q <= units_d;
			scale_q <= scale_d; timing_q <= timing_d;
			if (fin) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Failed parses report zeros in every field but the status.
	always_comb begin
		res_d = '0;
		res_d.status = fin_st;
		if (fin_st == ST_OK) begin
			res_d.pic_width       = width_q;
			res_d.pic_height      = height_q;
			res_d.interlaced      = !frame_only_q;
			res_d.cropping_on     = crop_flag_q;
			res_d.crop_right_px   = crop_r_q;
			res_d.crop_bottom_px  = crop_b_q;
			res_d.ref_frame_count = ref_q;
			res_d.timing_present  = timing_q;
			res_d.units_in_tick   = units_q;
			res_d.tick_time_scale = scale_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= res_d;
		end
	end

endmodule

FILE: rtl/h264_sps_header_parser_core.sv
// Sequence parameter set parser, fed one raw byte per transfer.
// Input channel: byte_valid/byte_stall with byte_item (data_byte, first_of_unit,
// last_of_unit). A byte marked first_of_unit restarts the parse.
// Result channel: res_valid/res_stall with res_item; one result per unit, at the
// byte that completes or fails the parse, or at the last byte of a short unit.
// Configuration: cfg_we/cfg_index/cfg_data; the user must write it only while the block is idle (unchecked).
// Bytes enter a four-entry queue, so the sender is stalled only when it is full.
// The parse engine fetches a byte from the queue, then consumes one bit per cycle
// until the byte or the parse ends; skipped or ignored bytes are dropped whole.
// A result appears on res_valid the cycle after its last bit is consumed.
// While a result is held on res_valid the engine fetches no new byte, so under
// res_stall the queue keeps taking bytes until it fills.
// Reset clears the queue and the parse and restores the skip count to 5 and the
// poc cycle limit to 128; bytes before the first unit start give no result.
module h264_sps_header_parser_core
	import sps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  in_item_t   byte_item,
	output logic       res_valid,
	input  logic       res_stall,
	output out_item_t  res_item
);

`include "assert_macros.svh"

	logic     q_valid;
	logic     q_pop;
	in_item_t q_head;

	sps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop)
	);

	sps_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	`SPS_ASSERT_SAME(a_pop_has_data, q_pop, q_valid)
	`SPS_ASSERT_SAME(a_fail_zero, res_valid && res_item.status != ST_OK, res_item.pic_width == '0 && res_item.timing_present == 1'b0)
	`SPS_ASSERT_SAME(a_no_timing, res_valid && !res_item.timing_present, res_item.units_in_tick == '0 && res_item.tick_time_scale == '0)
	`SPS_ASSERT_NEXT(a_pop_blocked, res_valid && res_stall, !q_pop)

endmodule
